// ----- hdl/dbba_pkg.sv -----
// Shared types and constants for the disk block bitmap allocator.
`timescale 1ns / 1ps

package dbba_pkg;

  localparam int unsigned BLK_W       = 7;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned ROW_BITS    = 8;
  localparam int unsigned SUM_W       = 9;
  localparam int unsigned RUN_END_MAX = 383;  // one past highest start plus longest run
  localparam int unsigned HEAD_SPAN   = 128;  // block numbers a 7-bit field reaches
  localparam int unsigned PEND_ROWS   = HEAD_SPAN / ROW_BITS;
  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned IN_USER_W   = 3;
  localparam int unsigned RES_W       = 18;
  localparam int unsigned OUT_DATA_W  = 24;

  typedef enum logic [1:0] {
    MODE_CONTIG  = 2'd0,
    MODE_INDEXED = 2'd1,
    MODE_LINKED  = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_USED  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MANY  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CONT_RD,
    S_CONT_CHK,
    S_CONT_WRD,
    S_CONT_WR,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_DATA_RD,
    S_DATA_CHK,
    S_FINISH,
    S_COMMIT_RD,
    S_COMMIT_WR,
    S_COMMIT_END,
    S_RESULT
  } state_t;

  typedef enum logic [2:0] {
    RES_CONT_RANGE,
    RES_CONT_USED,
    RES_CONT_OK,
    RES_REQ_FAIL,
    RES_REQ_OK
  } res_kind_t;

  typedef enum logic [1:0] {
    WSEL_CONT,
    WSEL_HEAD,
    WSEL_COMMIT
  } wsel_t;

  typedef struct packed {
    logic      load_item;
    logic      drop;
    logic      clear_map;
    logic      start_req;
    logic      fail;
    status_t   fail_code;
    logic      row_lo;
    logic      row_zero;
    logic      row_inc;
    logic      taken_clr;
    logic      taken_add;
    logic      addr_blk;
    logic      used_wr;
    wsel_t     used_wsel;
    logic      pend_wr;
    logic      res_load;
    res_kind_t res_kind;
    logic      out_push;
  } dbba_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  first;
    logic  last;
    logic  len_zero;
    logic  cont_oor;
    logic  head_oor;
    logic  in_request;
    logic  failed;
    logic  cnt_full;
    logic  row_at_hi;
    logic  row_at_end;
    logic  cont_hit;
    logic  used_bit;
    logic  pend_bit;
    logic  out_busy;
  } dbba_stat_t;

endpackage

// ----- hdl/dbba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dbba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- hdl/dbba_ctrl.sv -----
// Controller state machine sequencing map checks, claims and commits.
`timescale 1ns / 1ps

module dbba_ctrl import dbba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dbba_stat_t st,
  output dbba_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.mode) inside
          MODE_CLEAR: begin
            cmd.drop      = 1'b1;
            cmd.clear_map = 1'b1;
            state_nxt     = S_IDLE;
          end
          MODE_CONTIG: begin
            cmd.drop = 1'b1;
            if (st.cont_oor) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = RES_CONT_RANGE;
              state_nxt    = S_RESULT;
            end else if (st.len_zero) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = RES_CONT_OK;
              state_nxt    = S_RESULT;
            end else begin
              cmd.row_lo = 1'b1;
              state_nxt  = S_CONT_RD;
            end
          end
          MODE_INDEXED, MODE_LINKED: begin
            if (st.first) begin
              cmd.drop      = 1'b1;
              cmd.start_req = 1'b1;
              if (st.head_oor) begin
                cmd.fail      = 1'b1;
                cmd.fail_code = ST_RANGE;
                state_nxt     = st.last ? S_FINISH : S_IDLE;
              end else begin
                state_nxt = S_HEAD_RD;
              end
            end else if (!st.in_request) begin
              state_nxt = S_IDLE;
            end else if (st.failed) begin
              state_nxt = st.last ? S_FINISH : S_IDLE;
            end else if (st.mode == MODE_INDEXED && st.cnt_full) begin
              cmd.fail      = 1'b1;
              cmd.fail_code = ST_MANY;
              state_nxt     = st.last ? S_FINISH : S_IDLE;
            end else if (st.head_oor) begin
              cmd.fail      = 1'b1;
              cmd.fail_code = ST_RANGE;
              state_nxt     = st.last ? S_FINISH : S_IDLE;
            end else begin
              state_nxt = S_DATA_RD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_CONT_RD: begin
        state_nxt = S_CONT_CHK;
      end
      S_CONT_CHK: begin
        if (st.cont_hit) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_CONT_USED;
          state_nxt    = S_RESULT;
        end else if (st.row_at_hi) begin
          cmd.row_lo = 1'b1;
          state_nxt  = S_CONT_WRD;
        end else begin
          cmd.row_inc = 1'b1;
          state_nxt   = S_CONT_RD;
        end
      end
      S_CONT_WRD: begin
        state_nxt = S_CONT_WR;
      end
      S_CONT_WR: begin
        cmd.used_wr   = 1'b1;
        cmd.used_wsel = WSEL_CONT;
        if (st.row_at_hi) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_CONT_OK;
          state_nxt    = S_RESULT;
        end else begin
          cmd.row_inc = 1'b1;
          state_nxt   = S_CONT_WRD;
        end
      end
      S_HEAD_RD: begin
        cmd.addr_blk = 1'b1;
        state_nxt    = S_HEAD_CHK;
      end
      S_HEAD_CHK: begin
        cmd.addr_blk = 1'b1;
        if (st.used_bit) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = ST_USED;
        end else begin
          cmd.used_wr   = 1'b1;
          cmd.used_wsel = WSEL_HEAD;
        end
        state_nxt = st.last ? S_FINISH : S_IDLE;
      end
      S_DATA_RD: begin
        cmd.addr_blk = 1'b1;
        state_nxt    = S_DATA_CHK;
      end
      S_DATA_CHK: begin
        cmd.addr_blk = 1'b1;
        if (st.used_bit || (st.mode == MODE_LINKED && st.pend_bit)) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = ST_USED;
        end else begin
          cmd.pend_wr = 1'b1;
        end
        state_nxt = st.last ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        if (st.failed) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_REQ_FAIL;
          cmd.drop     = 1'b1;
          state_nxt    = S_RESULT;
        end else begin
          cmd.row_zero  = 1'b1;
          cmd.taken_clr = 1'b1;
          state_nxt     = S_COMMIT_RD;
        end
      end
      S_COMMIT_RD: begin
        state_nxt = S_COMMIT_WR;
      end
      S_COMMIT_WR: begin
        cmd.used_wr   = 1'b1;
        cmd.used_wsel = WSEL_COMMIT;
        cmd.taken_add = 1'b1;
        if (st.row_at_end) begin
          state_nxt = S_COMMIT_END;
        end else begin
          cmd.row_inc = 1'b1;
          state_nxt   = S_COMMIT_RD;
        end
      end
      S_COMMIT_END: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = RES_REQ_OK;
        cmd.drop     = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_RESULT: begin
        if (!st.out_busy) begin
          cmd.out_push = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/dbba_dp.sv -----
// Datapath: item register, used and pending bitmaps, request state, result register.
`timescale 1ns / 1ps

module dbba_dp import dbba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS        = 128,
  parameter int unsigned MAX_INDEX_ENTRIES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  in_tlast,
  input  dbba_cmd_t             cmd,
  output dbba_stat_t            st,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned MAP_BLOCKS = NUM_BLOCKS < RUN_END_MAX ? NUM_BLOCKS : RUN_END_MAX;
  localparam int unsigned ROWS       = (MAP_BLOCKS + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned PROWS      = ROWS < PEND_ROWS ? ROWS : PEND_ROWS;
  localparam int unsigned RW         = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int unsigned PRW        = PROWS > 1 ? $clog2(PROWS) : 1;
  localparam int unsigned CNTW       = $clog2(MAX_INDEX_ENTRIES + 1);
  localparam int unsigned SUM_LIM    = NUM_BLOCKS < 511 ? NUM_BLOCKS : 511;
  localparam int unsigned HEAD_LIM   = NUM_BLOCKS < HEAD_SPAN ? NUM_BLOCKS : HEAD_SPAN;
  localparam logic [SUM_W-1:0] SUM_LIM_V  = SUM_LIM[SUM_W-1:0];
  localparam logic [BLK_W:0]   HEAD_LIM_V = HEAD_LIM[BLK_W:0];
  localparam logic [CNTW-1:0]  MAX_CNT    = CNTW'(MAX_INDEX_ENTRIES);
  localparam logic [RW-1:0]    END_ROW    = RW'(PROWS - 1);

  mode_t              mode_r;
  logic               first_r, last_r;
  logic [BLK_W-1:0]   blk_r;
  logic [LEN_W-1:0]   len_r;
  logic [RW-1:0]      row_r, row_nxt;
  logic [ROWS-1:0]    used_vld_r, used_vld_nxt;
  logic [PROWS-1:0]   pend_vld_r, pend_vld_nxt;
  logic               in_req_r, in_req_nxt;
  logic               failed_r, failed_nxt;
  status_t            code_r, code_nxt;
  logic [BLK_W-1:0]   held_r, held_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic [LEN_W-1:0]   taken_r;
  logic [RES_W-1:0]   res_r, res_nxt;
  logic [RES_W-1:0]   out_data_r;
  logic               out_valid_r;

  logic [SUM_W-1:0]    lo9, sum9, hi9, lo_row9, hi_row9, base9, pos9;
  logic [RW-1:0]       blk_row, hi_row, addr;
  logic [PRW-1:0]      paddr;
  logic [ROW_BITS-1:0] mask, bit_oh, used_rdata, pend_rdata, used_eff, pend_eff;
  logic [ROW_BITS-1:0] used_wdata, pend_wdata;
  logic [3:0]          pend_cnt;

  always_comb begin
    lo9     = {2'b00, blk_r};
    sum9    = lo9 + {1'b0, len_r};
    hi9     = sum9 - SUM_W'(1);
    lo_row9 = lo9 >> 3;
    hi_row9 = hi9 >> 3;
    blk_row = lo_row9[RW-1:0];
    hi_row  = hi_row9[RW-1:0];
    base9   = '0;
    base9[RW+2:0] = {row_r, 3'b000};
    for (int i = 0; i < ROW_BITS; i++) begin
      pos9    = base9 + SUM_W'(i);
      mask[i] = (pos9 >= lo9) && (pos9 < sum9);
    end
  end

  assign addr     = cmd.addr_blk ? blk_row : row_r;
  assign paddr    = addr[PRW-1:0];
  assign bit_oh   = ROW_BITS'(1) << blk_r[2:0];
  assign used_eff = used_rdata & {ROW_BITS{used_vld_r[addr]}};
  assign pend_eff = pend_rdata & {ROW_BITS{pend_vld_r[paddr]}};

  always_comb begin
    case (cmd.used_wsel)
      WSEL_CONT:   used_wdata = used_eff | mask;
      WSEL_HEAD:   used_wdata = used_eff | bit_oh;
      WSEL_COMMIT: used_wdata = used_eff | pend_eff;
      default:     used_wdata = used_eff;
    endcase
  end

  assign pend_wdata = pend_eff | bit_oh;

  always_comb begin
    pend_cnt = '0;
    for (int i = 0; i < ROW_BITS; i++) begin
      pend_cnt = pend_cnt + 4'(pend_eff[i]);
    end
  end

  dbba_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_used_ram (
    .clk   (clk),
    .we    (cmd.used_wr),
    .waddr (addr),
    .wdata (used_wdata),
    .raddr (addr),
    .rdata (used_rdata)
  );

  dbba_ram #(.WIDTH(ROW_BITS), .DEPTH(PROWS)) u_pend_ram (
    .clk   (clk),
    .we    (cmd.pend_wr),
    .waddr (paddr),
    .wdata (pend_wdata),
    .raddr (paddr),
    .rdata (pend_rdata)
  );

  // request bookkeeping; a drop and a new head may land in the same cycle
  always_comb begin
    in_req_nxt   = in_req_r;
    failed_nxt   = failed_r;
    code_nxt     = code_r;
    held_nxt     = held_r;
    cnt_nxt      = cnt_r;
    pend_vld_nxt = pend_vld_r;
    used_vld_nxt = used_vld_r;
    if (cmd.drop) begin
      in_req_nxt   = 1'b0;
      failed_nxt   = 1'b0;
      code_nxt     = ST_OK;
      cnt_nxt      = '0;
      pend_vld_nxt = '0;
    end
    if (cmd.clear_map) begin
      used_vld_nxt = '0;
    end
    if (cmd.start_req) begin
      in_req_nxt = 1'b1;
      held_nxt   = blk_r;
    end
    if (cmd.fail && !failed_nxt) begin
      failed_nxt = 1'b1;
      code_nxt   = cmd.fail_code;
    end
    if (cmd.used_wr) begin
      used_vld_nxt[addr] = 1'b1;
    end
    if (cmd.pend_wr) begin
      pend_vld_nxt[paddr] = 1'b1;
      if (cnt_r < MAX_CNT) begin
        cnt_nxt = cnt_r + CNTW'(1);
      end
    end
  end

  always_comb begin
    row_nxt = row_r;
    if (cmd.row_lo) begin
      row_nxt = blk_row;
    end else if (cmd.row_zero) begin
      row_nxt = '0;
    end else if (cmd.row_inc) begin
      row_nxt = row_r + RW'(1);
    end
  end

  // result word: granted, status, head_block, blocks_taken from bit 0 up
  always_comb begin
    case (cmd.res_kind)
      RES_CONT_RANGE: res_nxt = {LEN_W'(0), blk_r, ST_RANGE, 1'b0};
      RES_CONT_USED:  res_nxt = {LEN_W'(0), blk_r, ST_USED, 1'b0};
      RES_CONT_OK:    res_nxt = {len_r, blk_r, ST_OK, 1'b1};
      RES_REQ_FAIL:   res_nxt = {LEN_W'(0), held_r, code_r, 1'b0};
      RES_REQ_OK:     res_nxt = {taken_r, held_r, ST_OK, 1'b1};
      default:        res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_vld_r  <= '0;
      pend_vld_r  <= '0;
      in_req_r    <= 1'b0;
      failed_r    <= 1'b0;
      code_r      <= ST_OK;
      held_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_vld_r <= used_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      in_req_r   <= in_req_nxt;
      failed_r   <= failed_nxt;
      code_r     <= code_nxt;
      held_r     <= held_nxt;
      cnt_r      <= cnt_nxt;
      if (cmd.out_push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r  <= mode_t'(in_tuser[1:0]);
      first_r <= in_tuser[2];
      last_r  <= in_tlast;
      blk_r   <= in_tdata[BLK_W-1:0];
      len_r   <= in_tdata[BLK_W +: LEN_W];
    end
    row_r <= row_nxt;
    if (cmd.taken_clr) begin
      taken_r <= '0;
    end else if (cmd.taken_add) begin
      taken_r <= taken_r + LEN_W'(pend_cnt);
    end
    if (cmd.res_load) begin
      res_r <= res_nxt;
    end
    if (cmd.out_push) begin
      out_data_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - RES_W)'(0), out_data_r};

  always_comb begin
    st            = '0;
    st.mode       = mode_r;
    st.first      = first_r;
    st.last       = last_r;
    st.len_zero   = (len_r == '0);
    st.cont_oor   = (sum9 > SUM_LIM_V);
    st.head_oor   = ({1'b0, blk_r} >= HEAD_LIM_V);
    st.in_request = in_req_r;
    st.failed     = failed_r;
    st.cnt_full   = (cnt_r >= MAX_CNT);
    st.row_at_hi  = (row_r == hi_row);
    st.row_at_end = (row_r == END_ROW);
    st.cont_hit   = |(used_eff & mask);
    st.used_bit   = |(used_eff & bit_oh);
    st.pend_bit   = |(pend_eff & bit_oh);
    st.out_busy   = out_valid_r && !out_tready;
  end

endmodule

// ----- hdl/disk_block_bitmap_allocator_unit.sv -----
// Disk block bitmap allocator: top level joining controller and datapath.
//
// Usage: each input word is one allocation item. A contiguous item (start, length)
// is checked and claimed in one go; an indexed or linked request is a head word
// (first set) followed by data words; the head block is claimed when it is checked,
// the data blocks are committed all or nothing on the word with tlast. A clear word
// empties the whole map. At most one result word per item.
// Timing: the block takes one item at a time. A contiguous item makes two passes
// over the used-map RAM, one read then one write per bitmap row of 8 blocks in the run.
// A request that ends with a commit sweeps its min(ceil(NUM_BLOCKS/8), 16) pending
// rows, then answers.
// Reset: synchronous, active low; the map, the pending set and the open request
// are empty afterwards, with no clearing pass.
// Stall: results wait in an output register; a new item is still taken while one
// waits, and the block holds in its answer state only if a second result is
// ready before the first was taken.
`timescale 1ns / 1ps

module disk_block_bitmap_allocator_unit import dbba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS        = 128,
  parameter int unsigned MAX_INDEX_ENTRIES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // block[6:0], length[14:7]
  input  logic [IN_USER_W-1:0]  in_tuser,   // mode[1:0], first[2]
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // granted[0], status[2:1], head_block[9:3],
                                            // blocks_taken[17:10]
);

  dbba_cmd_t  cmd;
  dbba_stat_t st;

  dbba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  dbba_dp #(
    .NUM_BLOCKS        (NUM_BLOCKS),
    .MAX_INDEX_ENTRIES (MAX_INDEX_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
